[rtl/pfe_pkg.sv]
// Shared types, constants and CRC helpers for the packet frame encoder.
package pfe_pkg;

   // Largest payload a header may announce.
   localparam int MaxPayload = 512;
   localparam int LenW       = $clog2(MaxPayload + 1);

   // Command queue between the front and back parts.
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);

   localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
   localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_TYPE = 2'd1,
      ST_BAD_TR   = 2'd2,
      ST_BAD_LEN  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CK_HDR = 2'd0,
      CK_ERR = 2'd1,
      CK_PAY = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_HDR  = 2'd1,
      BK_FCS  = 2'd2
   } bk_state_type;

   localparam logic [1:0] PktTypeInvalid = 2'd0;
   localparam logic [1:0] PktTypeData    = 2'd1;

   // One classified request, as handed from the front to the back.
   typedef struct packed {
      cmd_kind_type      kind;
      status_type        status;
      logic              last;
      logic [1:0]        pkt_type;
      logic              trunc_bit;
      logic [4:0]        window_size;
      logic [7:0]        seq_number;
      logic [LenW-1:0]   payload_length;
      logic [31:0]       time_stamp;
      logic [7:0]        data_byte;
   } cmd_type;

   // Reflected CRC-32 register update by one byte (no final inversion).
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // The first eight bytes of a header block.
   function automatic logic [7:0] hdr_byte(input cmd_type c, input logic [2:0] idx);
      logic [15:0] len16;
      logic [7:0]  b;
      len16 = 16'(c.payload_length);
      unique case (idx)
         3'd0: b = {c.pkt_type, c.trunc_bit, c.window_size};
         3'd1: b = c.seq_number;
         3'd2: b = len16[7:0];
         3'd3: b = len16[15:8];
         3'd4: b = c.time_stamp[7:0];
         3'd5: b = c.time_stamp[15:8];
         3'd6: b = c.time_stamp[23:16];
         3'd7: b = c.time_stamp[31:24];
      endcase
      return b;
   endfunction

endpackage

[rtl/pfe_front.sv]
// Front part: checks headers, tracks the open payload and classifies requests.
module pfe_front
   import pfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          op,
   input  logic [1:0]    pkt_type,
   input  logic          trunc_bit,
   input  logic [4:0]    window_size,
   input  logic [7:0]    seq_number,
   input  logic [15:0]   payload_length,
   input  logic [31:0]   time_stamp,
   input  logic [7:0]    data_byte,
   output logic          push,
   output cmd_type       push_cmd
);

   logic            expecting_ff, expecting_in;
   logic [LenW-1:0] remaining_ff, remaining_in;
   status_type      status;

   always_comb begin
      if (pkt_type == PktTypeInvalid) begin
         status = ST_BAD_TYPE;
      end else if (pkt_type != PktTypeData && trunc_bit) begin
         status = ST_BAD_TR;
      end else if (payload_length > 16'(MaxPayload)) begin
         status = ST_BAD_LEN;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      expecting_in = expecting_ff;
      remaining_in = remaining_ff;
      push         = 1'b0;

      push_cmd.kind           = CK_PAY;
      push_cmd.status         = status;
      push_cmd.last           = (remaining_ff == LenW'(1));
      push_cmd.pkt_type       = pkt_type;
      push_cmd.trunc_bit      = trunc_bit;
      push_cmd.window_size    = window_size;
      push_cmd.seq_number     = seq_number;
      push_cmd.payload_length = payload_length[LenW-1:0];
      push_cmd.time_stamp     = time_stamp;
      push_cmd.data_byte      = data_byte;

      if (accept) begin
         if (!op) begin
            // A header always abandons whatever frame is open.
            push          = 1'b1;
            push_cmd.kind = (status == ST_OK) ? CK_HDR : CK_ERR;
            expecting_in  = (status == ST_OK) && (payload_length != 16'd0);
            remaining_in  = payload_length[LenW-1:0];
         end else if (expecting_ff) begin
            push         = 1'b1;
            remaining_in = remaining_ff - LenW'(1);
            if (remaining_ff == LenW'(1)) begin
               expecting_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expecting_ff <= 1'b0;
         remaining_ff <= '0;
      end else begin
         expecting_ff <= expecting_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

[rtl/pfe_queue.sv]
// Short command queue between the front and back parts.
module pfe_queue
   import pfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type          mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]   count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == (QPtrW + 1)'(QDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (QPtrW + 1)'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - (QPtrW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/pfe_back.sv]
// Back part: serializes commands into frame bytes and keeps the running CRC.
module pfe_back
   import pfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic       rsp_tlast
);

   bk_state_type state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   cmd_type      cur_ff, cur_in;
   logic [31:0]  crc_ff, crc_in;
   logic [31:0]  fcs_ff, fcs_in;

   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   status_type   out_status_ff, out_status_in;
   logic         out_last_ff, out_last_in;

   logic         adv;
   logic         emit;
   logic [7:0]   emit_byte;
   status_type   emit_status;
   logic         emit_last;

   // The output register may load whenever it is empty or being drained.
   assign adv = !out_valid_ff || rsp_tready;

   // Next state and byte counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (adv && cmd_valid) begin
               if (cmd.kind == CK_HDR) begin
                  state_in = BK_HDR;
                  cnt_in   = 4'd1;
               end else if (cmd.kind == CK_PAY && cmd.last) begin
                  state_in = BK_FCS;
                  cnt_in   = 4'd0;
               end
            end
         end
         BK_HDR: begin
            if (adv) begin
               if (cnt_ff == 4'd11) begin
                  state_in = BK_IDLE;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         BK_FCS: begin
            if (adv) begin
               if (cnt_ff == 4'd3) begin
                  state_in = BK_IDLE;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Emitted byte and CRC datapath.
   always_comb begin
      pop         = 1'b0;
      emit        = 1'b0;
      emit_byte   = 8'd0;
      emit_status = ST_OK;
      emit_last   = 1'b0;
      cur_in      = cur_ff;
      crc_in      = crc_ff;
      fcs_in      = fcs_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (adv && cmd_valid) begin
               pop  = 1'b1;
               emit = 1'b1;
               case (cmd.kind)
                  CK_ERR: begin
                     emit_status = cmd.status;
                     emit_last   = 1'b1;
                  end
                  CK_PAY: begin
                     emit_byte = cmd.data_byte;
                     crc_in    = crc_byte(crc_ff, cmd.data_byte);
                     fcs_in    = ~crc_in;
                  end
                  CK_HDR: begin
                     emit_byte = hdr_byte(cmd, 3'd0);
                     crc_in    = crc_byte(AllOnes, emit_byte);
                     cur_in    = cmd;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         BK_HDR: begin
            if (adv) begin
               emit = 1'b1;
               if (cnt_ff[3]) begin
                  emit_byte = fcs_ff[{cnt_ff[1:0], 3'b000} +: 8];
               end else begin
                  emit_byte = hdr_byte(cur_ff, cnt_ff[2:0]);
               end
               crc_in = crc_byte(crc_ff, emit_byte);
               if (cnt_ff == 4'd7) begin
                  fcs_in = ~crc_in;
               end
               emit_last = (cnt_ff == 4'd11) && (cur_ff.payload_length == '0);
            end
         end
         BK_FCS: begin
            if (adv) begin
               emit      = 1'b1;
               emit_byte = fcs_ff[{cnt_ff[1:0], 3'b000} +: 8];
               emit_last = (cnt_ff == 4'd3);
               if (cnt_ff == 4'd3) begin
                  crc_in = AllOnes;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      out_valid_in  = adv ? emit : out_valid_ff;
      out_byte_in   = adv ? emit_byte : out_byte_ff;
      out_status_in = adv ? emit_status : out_status_ff;
      out_last_in   = adv ? emit_last : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         crc_ff       <= AllOnes;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      fcs_ff        <= fcs_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/packet_frame_encoder_crc32_top.sv]
// Top level of the packet frame encoder with CRC-32 trailers.
//
// The request channel (req_) carries either a header or one payload byte,
// selected by req_tuser. A header is checked (type, truncation flag, length)
// and becomes a 12-byte header block: type/flag/window, sequence number,
// length and timestamp little-endian, then the CRC-32 of those eight bytes.
// A failed check yields a single response with a zero byte, the error code
// in rsp_tuser and rsp_tlast set. The announced payload bytes are echoed one
// response each; after the last one the CRC-32 over the whole frame follows
// as four bytes, the final one marked with rsp_tlast. Payload bytes that
// arrive while no payload is open produce nothing; a new header abandons
// any open frame.
//
// With the back part idle, the queue entry written at the edge that accepts
// a request is loaded into the output register at the next one. Payload
// bytes stream at one per cycle while rsp_tready is high; a header block is
// 12 bytes, the final payload byte is followed by four CRC bytes and an
// error response is a single byte. The output rate is set by the back
// sequencer, one byte per cycle while rsp_tready is high; a four-entry
// command queue lets requests keep arriving while a header is serialized.
// When the receiver holds rsp_tready low the output register holds, the
// queue fills and req_tready drops. Reset empties the queue, closes any open
// frame and clears the output register; there is no clearing pass.
module packet_frame_encoder_crc32_top
   import pfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, from bit 0: pkt_type[1:0], trunc_bit[2], window_size[7:3],
   // seq_number[15:8], payload_length[31:16], time_stamp[63:32], data_byte[71:64].
   input  logic [71:0] req_tdata,
   // req_tuser: op (0 = header request, 1 = payload byte).
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: out_byte[7:0].
   output logic [7:0]  rsp_tdata,
   // rsp_tuser: status[1:0] (0 ok, 1 bad type, 2 flag on non-data type, 3 too long).
   output logic [1:0]  rsp_tuser,
   // rsp_tlast: frame_last.
   output logic        rsp_tlast
);

   logic    q_full;
   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   pfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (req_tuser),
      .pkt_type       (req_tdata[1:0]),
      .trunc_bit      (req_tdata[2]),
      .window_size    (req_tdata[7:3]),
      .seq_number     (req_tdata[15:8]),
      .payload_length (req_tdata[31:16]),
      .time_stamp     (req_tdata[63:32]),
      .data_byte      (req_tdata[71:64]),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   pfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/pfe_checker.sv]
// Port-level checks for the packet frame encoder, bound to the top level.
module pfe_checker
   import pfe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled response keeps its byte, status and end mark.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // An error response is a lone zero byte that ends the frame.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("malformed error response");

   // Reset leaves no response pending.
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Reset leaves the command queue empty, so requests are taken.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request channel not ready after reset");

   // With requests as the sole source of responses, a response cannot appear
   // when the sampled history shows no request, response or reset.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !$past(req_tvalid, 1) && !$past(req_tvalid, 2) && !$past(rsp_tvalid, 1)
         && !$past(rsp_tvalid, 2) && !$past(reset, 1) && !$past(reset, 2)
         && $past(req_tready, 1) && $past(req_tready, 2) && $past(req_tready, 3)
         && !$past(req_tvalid, 3) && !$past(rsp_tvalid, 3) && !$past(reset, 3)
         |-> !rsp_tvalid)
      else $error("response without a request");

endmodule

bind packet_frame_encoder_crc32_top pfe_checker u_pfe_checker (.*);
